// ===== hdl/swa_pkg.sv =====
// Shared constants and width helpers for the sliding window average unit.
`timescale 1ns / 1ps
`default_nettype none
package swa_pkg;

   localparam int WINDOW_DEFAULT      = 100;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int FILL_COUNT_BITS     = 7;

   // Bits needed to hold a count from 0 up to the window length.
   function automatic int count_bits(input int window);
      return $clog2(window + 1);
   endfunction

   // Bits of the signed running sum of a full window.
   function automatic int sum_bits(input int window, input int sample_bits);
      return sample_bits + $clog2(window);
   endfunction

   // Bits of a slot index into the sample ring.
   function automatic int pointer_bits(input int window);
      return (window > 1) ? $clog2(window) : 1;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/swa_front.sv =====
// Front end: sample ring, running sum and fill count; hands sum and count to the queue.
`timescale 1ns / 1ps
`default_nettype none
module swa_front #(
   parameter int WINDOW      = swa_pkg::WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEFAULT,
   parameter int CNT_W       = swa_pkg::count_bits(WINDOW),
   parameter int SUM_W       = swa_pkg::sum_bits(WINDOW, SAMPLE_BITS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output logic [SUM_W-1:0]            push_sum,
   output logic [CNT_W-1:0]            push_count
);

   localparam int PTR_W = swa_pkg::pointer_bits(WINDOW);

   logic [SAMPLE_BITS-1:0] ring [WINDOW];

   logic                   busy_ff, busy_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   full_ff, full_in;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SAMPLE_BITS-1:0] oldest_ff;
   logic                   accept;
   logic [SUM_W-1:0]       sum_next;

   assign accept    = req_valid && !req_stall;
   assign req_stall = busy_ff;

   // New sum: add the incoming sample, drop the oldest once the window is full.
   always_comb begin
      sum_next = sum_ff + SUM_W'(signed'(sample_ff));
      if (full_ff) begin
         sum_next = sum_next - SUM_W'(signed'(oldest_ff));
      end
   end

   assign push_valid = busy_ff;
   assign push_sum   = sum_next;
   assign push_count = count_ff;

   always_comb begin
      busy_in  = busy_ff;
      ptr_in   = ptr_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      full_in  = full_ff;
      if (accept) begin
         busy_in = 1'b1;
         full_in = (count_ff == CNT_W'(WINDOW));
         if (count_ff != CNT_W'(WINDOW)) begin
            count_in = count_ff + CNT_W'(1);
         end
         ptr_in = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + PTR_W'(1);
      end else if (busy_ff && push_ready) begin
         busy_in = 1'b0;
         sum_in  = sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         ptr_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         full_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         full_ff  <= full_in;
      end
   end

   // Read the oldest sample and overwrite its slot in the same beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         ring[ptr_ff] <= req_sample;
         oldest_ff    <= ring[ptr_ff];
         sample_ff    <= req_sample;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/swa_queue.sv =====
// Two-entry queue of sum and count between the front end and the divider.
`timescale 1ns / 1ps
`default_nettype none
module swa_queue #(
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output logic [DATA_W-1:0]      pop_data
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [1:0]        level_ff, level_in;
   logic              push, pop;

   assign push_ready = (level_ff != 2'd2);
   assign pop_valid  = (level_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      level_in = level_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         level_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/swa_divider.sv =====
// Back end: signed restoring divide of sum by count, one quotient bit a cycle, output register.
`timescale 1ns / 1ps
`default_nettype none
module swa_divider #(
   parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEFAULT,
   parameter int CNT_W       = swa_pkg::count_bits(swa_pkg::WINDOW_DEFAULT),
   parameter int SUM_W       = swa_pkg::sum_bits(swa_pkg::WINDOW_DEFAULT,
                                                 swa_pkg::SAMPLE_BITS_DEFAULT)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire logic [SUM_W-1:0]       pop_sum,
   input  wire logic [CNT_W-1:0]       pop_count,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0]      rsp_average,
   output logic [swa_pkg::FILL_COUNT_BITS-1:0] rsp_fill_count
);

   localparam int IT_W = $clog2(SUM_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [IT_W-1:0]        iter_ff, iter_in;
   logic [SUM_W-1:0]       dq_ff, dq_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]       div_ff, div_in;
   logic                   neg_ff, neg_in;
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] avg_ff;
   logic [CNT_W-1:0]       cnt_out_ff;
   logic [CNT_W:0]         trial;
   logic                   fits;
   logic                   out_free;
   logic                   load_out;
   logic [SUM_W-1:0]       signed_q;
   logic [31:0]            cnt_wide;

   assign trial     = {rem_ff, dq_ff[SUM_W-1]};
   assign fits      = (trial >= {1'b0, div_ff});
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign load_out  = (state_ff == ST_DONE) && out_free;
   assign pop_ready = (state_ff == ST_IDLE);
   assign signed_q  = neg_ff ? (SUM_W'(0) - dq_ff) : dq_ff;

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               neg_in   = pop_sum[SUM_W-1];
               dq_in    = pop_sum[SUM_W-1] ? (SUM_W'(0) - pop_sum) : pop_sum;
               div_in   = pop_count;
               rem_in   = '0;
               iter_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = fits ? CNT_W'(trial - {1'b0, div_ff}) : CNT_W'(trial);
            dq_in   = {dq_ff[SUM_W-2:0], fits};
            iter_in = iter_ff + IT_W'(1);
            if (iter_ff == IT_W'(SUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      if (load_out) begin
         avg_ff     <= signed_q[SAMPLE_BITS-1:0];
         cnt_out_ff <= div_ff;
      end
   end

   assign cnt_wide       = 32'(cnt_out_ff);
   assign rsp_valid      = out_valid_ff;
   assign rsp_average    = avg_ff;
   assign rsp_fill_count = cnt_wide[swa_pkg::FILL_COUNT_BITS-1:0];

endmodule
`default_nettype wire

// ===== hdl/sliding_window_average_unit.sv =====
// Top level of the sliding window average unit: front end, queue and divider.
`timescale 1ns / 1ps
`default_nettype none
// Boxcar moving average over the last WINDOW signed Q8.8 samples. Each
// accepted req_ beat gives exactly one rsp_ beat, in order: the mean of the
// held samples (sum over count, truncated toward zero) and the number of
// samples held, which climbs from 1 and then stays at WINDOW. For each
// sample the front end first writes it into the ring and reads the oldest
// sample, then updates the running sum and pushes sum and count into a
// two-entry queue, holding req_stall until the queue takes them. The divider
// behind the queue produces one quotient bit a cycle over the SUM_W bits of
// the sum (SUM_W being SAMPLE_BITS + clog2(WINDOW)) and takes a new sum only
// once its last result has gone to the output register; that divide sets the
// sustained rate. The queue and the output register let the front end take
// further samples while the divider works or while a finished result waits
// under rsp_stall. Ring contents need no clearing after reset: the oldest
// sample read from a slot is only used once that slot has been written.
module sliding_window_average_unit #(
   parameter int WINDOW      = swa_pkg::WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0]      rsp_average,
   output logic [swa_pkg::FILL_COUNT_BITS-1:0] rsp_fill_count
);

   // Count reaches WINDOW itself; the sum holds WINDOW full-scale samples.
   localparam int CNT_W = swa_pkg::count_bits(WINDOW);
   localparam int SUM_W = swa_pkg::sum_bits(WINDOW, SAMPLE_BITS);

   logic             push_valid;
   logic             push_ready;
   logic [SUM_W-1:0] push_sum;
   logic [CNT_W-1:0] push_count;
   logic             pop_valid;
   logic             pop_ready;
   logic [SUM_W+CNT_W-1:0] pop_data;

   // Ring, running sum and fill count.
   swa_front #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_sum   (push_sum),
      .push_count (push_count)
   );

   // Decouple the front end from the divide.
   swa_queue #(
      .DATA_W (SUM_W + CNT_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_sum, push_count}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Serial divide and the result register.
   swa_divider #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W)
   ) u_divider (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_sum        (pop_data[SUM_W+CNT_W-1:CNT_W]),
      .pop_count      (pop_data[CNT_W-1:0]),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_average    (rsp_average),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule
`default_nettype wire
